// ===== rtl/core/mtw_pkg.sv =====
package mtw_pkg;

    // Register map of the configuration port
    typedef enum logic [2:0] {
        CFG_START_X  = 3'd0,
        CFG_START_Y  = 3'd1,
        CFG_START_Z  = 3'd2,
        CFG_DEST_X   = 3'd3,
        CFG_DEST_Y   = 3'd4,
        CFG_DEST_Z   = 3'd5,
        CFG_FIX_TIME = 3'd6,
        CFG_SPEED    = 3'd7
    } t_cfg_idx;

    // Distance sequencer states
    typedef enum logic [1:0] {
        DS_WAIT,
        DS_SQUARE,
        DS_ROOT,
        DS_DONE
    } t_dist_state;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 16;
    localparam int PROD_W     = TIME_W + SPEED_W;
    localparam int MS_PER_S   = 1000;
    localparam int MS_PER_S_W = 10;
    localparam int AXES       = 3;

endpackage

// ===== rtl/core/mtw_div.sv =====
// Restoring divider, one quotient bit per stage, several lanes sharing a divisor.
// Requires num < den * 2**QW for a meaningful quotient.
module mtw_div #(
    parameter int LANES = 1,
    parameter int QW    = 8,
    parameter int DW    = 8,
    parameter int SW    = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [LANES-1:0][QW+DW-1:0]     i_num,
    input  logic [DW-1:0]                   i_den,
    input  logic [SW-1:0]                   i_side,
    output logic                            o_valid,
    output logic [LANES-1:0][QW-1:0]        o_quo,
    output logic [SW-1:0]                   o_side
);

    logic                         r_v    [0:QW];
    logic [LANES-1:0][QW-1:0]     r_lq   [0:QW];
    logic [SW-1:0]                r_side [0:QW];
    logic [LANES-1:0][DW-1:0]     r_rem  [0:QW-1];
    logic [DW-1:0]                r_den  [0:QW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_den[0]  <= i_den;
            for (int l = 0; l < LANES; l++) begin
                r_rem[0][l] <= i_num[l][QW+DW-1:QW];
                r_lq[0][l]  <= i_num[l][QW-1:0];
            end
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [LANES-1:0][DW:0] trial;
        logic [LANES-1:0][DW:0] diff;
        logic [LANES-1:0]       ge;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = {r_rem[k-1][l], r_lq[k-1][l][QW-1]};
                diff[l]  = trial[l] - {1'b0, r_den[k-1]};
                ge[l]    = (trial[l] >= {1'b0, r_den[k-1]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        // numerator bits shift out at the top, quotient bits shift in below
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= r_side[k-1];
                for (int l = 0; l < LANES; l++) begin
                    r_lq[k][l] <= {r_lq[k-1][l][QW-2:0], ge[l]};
                end
            end
        end

        if (k < QW) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= r_den[k-1];
                    for (int l = 0; l < LANES; l++) begin
                        r_rem[k][l] <= ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
                    end
                end
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_lq[QW];
    assign o_side  = r_side[QW];

endmodule

// ===== rtl/core/mtw_dist.sv =====
// Start-to-waypoint distance: sum of squares, then floor square root, two bits a step.
module mtw_dist #(
    parameter int COORD_BITS = 24
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic [mtw_pkg::AXES-1:0][COORD_BITS-1:0] i_absd,
    output logic                                     o_ready,
    output logic [COORD_BITS:0]                      o_dist
);

    localparam int SQ_W  = 2 * COORD_BITS + 2;
    localparam int SQP_W = 2 * COORD_BITS;
    localparam int REM_W = COORD_BITS + 4;
    localparam int CNT_W = $clog2(COORD_BITS + 1);
    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(mtw_pkg::AXES);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(COORD_BITS);

    mtw_pkg::t_dist_state r_state, n_state;

    logic [CNT_W-1:0]      r_cnt;
    logic [COORD_BITS-1:0] r_ad;
    logic [SQ_W-1:0]       r_acc;
    logic [REM_W-1:0]      r_rem;
    logic [COORD_BITS:0]   r_root;
    logic [COORD_BITS-1:0] ad_sel;
    logic [SQP_W-1:0]      sq;
    logic [REM_W-1:0]      rem_try;
    logic [REM_W-1:0]      root_trial;
    logic                  root_ge;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mtw_pkg::DS_WAIT:   n_state = mtw_pkg::DS_SQUARE;
            mtw_pkg::DS_SQUARE: if (r_cnt == SQ_LAST) n_state = mtw_pkg::DS_ROOT;
            mtw_pkg::DS_ROOT:   if (r_cnt == ROOT_LAST) n_state = mtw_pkg::DS_DONE;
            mtw_pkg::DS_DONE:   n_state = mtw_pkg::DS_DONE;
            default:            n_state = mtw_pkg::DS_WAIT;
        endcase
        // any register write restarts the computation
        if (i_start) begin
            n_state = mtw_pkg::DS_WAIT;
        end
    end

    always_comb begin
        o_ready = (r_state == mtw_pkg::DS_DONE);
        o_dist  = r_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtw_pkg::DS_WAIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else if (r_state != mtw_pkg::DS_DONE) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_comb begin
        case (r_cnt)
            CNT_W'(0): ad_sel = i_absd[0];
            CNT_W'(1): ad_sel = i_absd[1];
            CNT_W'(2): ad_sel = i_absd[2];
            default:   ad_sel = '0;
        endcase
        sq         = SQP_W'(r_ad) * SQP_W'(r_ad);
        rem_try    = {r_rem[REM_W-3:0], r_acc[SQ_W-1:SQ_W-2]};
        root_trial = {1'b0, r_root, 2'b01};
        root_ge    = (rem_try >= root_trial);
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mtw_pkg::DS_SQUARE: begin
                r_ad   <= ad_sel;
                r_acc  <= (r_cnt == '0) ? '0 : r_acc + SQ_W'(sq);
                r_rem  <= '0;
                r_root <= '0;
            end
            mtw_pkg::DS_ROOT: begin
                r_acc  <= r_acc << 2;
                r_rem  <= root_ge ? rem_try - root_trial : rem_try;
                r_root <= {r_root[COORD_BITS-1:0], root_ge};
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/move_toward_waypoint_estimator.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+---------------------------------------
// query    | i_in_valid / o_in_ready   | i_query_time
// estimate | o_out_valid / i_out_ready | o_est_x, o_est_y, o_est_z, o_reached
// config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per cycle once the distance is known and no estimate is held; the two
// bit-per-stage dividers make up most of the pipeline depth.
// After reset and after every register write the distance unit redoes the square
// accumulation and root loop; queries wait meanwhile.
// Synchronous active-low reset clears valids, configuration registers and the distance sequencer.
// A held estimate freezes the whole pipeline; nothing is dropped or repeated.
module move_toward_waypoint_estimator #(
    parameter int COORD_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [mtw_pkg::TIME_W-1:0]         i_query_time,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [COORD_BITS-1:0]       o_est_x,
    output logic signed [COORD_BITS-1:0]       o_est_y,
    output logic signed [COORD_BITS-1:0]       o_est_z,
    output logic                               o_reached,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mtw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mtw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int DIST_W = COORD_BITS + 1;
    localparam int X_W    = DIST_W + mtw_pkg::MS_PER_S_W;
    localparam int NUM_W  = COORD_BITS + DIST_W;
    // travel saturates the distance range beyond this product
    localparam logic [mtw_pkg::PROD_W-1:0] SAT_LIM =
        mtw_pkg::PROD_W'(mtw_pkg::MS_PER_S) << DIST_W;

    // configuration
    logic [COORD_BITS-1:0]          r_start [mtw_pkg::AXES];
    logic [COORD_BITS-1:0]          r_dest  [mtw_pkg::AXES];
    logic [mtw_pkg::TIME_W-1:0]     r_fix_time;
    logic [mtw_pkg::SPEED_W-1:0]    r_speed;
    logic                           cfg_we;

    // per-axis magnitude and direction of the leg
    logic [mtw_pkg::AXES-1:0][COORD_BITS-1:0] r_absd;
    logic [mtw_pkg::AXES-1:0]                 r_neg;

    logic              dist_ready;
    logic [DIST_W-1:0] leg_len;
    logic              en;

    logic                         r_a_v;
    logic [mtw_pkg::TIME_W-1:0]   r_a_elapsed;
    logic                         r_b_v;
    logic [mtw_pkg::PROD_W-1:0]   r_b_prod;
    logic                         r_c_v;
    logic [X_W-1:0]               r_c_x;
    logic                         r_c_reached;

    logic                  div1_v;
    logic [DIST_W-1:0]     div1_quo;
    logic                  div1_side;

    logic                  r_d_v;
    logic [DIST_W-1:0]     r_d_travel;
    logic                  r_d_reached;
    logic                  r_e_v;
    logic [mtw_pkg::AXES-1:0][NUM_W-1:0] r_e_prod;
    logic                  r_e_reached;

    logic                  div2_v;
    logic [mtw_pkg::AXES-1:0][COORD_BITS-1:0] div2_quo;
    logic                  div2_side;

    logic                           r_out_valid;
    logic [COORD_BITS-1:0]          r_est [mtw_pkg::AXES];
    logic                           r_reached;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < mtw_pkg::AXES; a++) begin
                r_start[a] <= '0;
                r_dest[a]  <= '0;
            end
            r_fix_time <= '0;
            r_speed    <= mtw_pkg::SPEED_W'(1);
        end else if (cfg_we) begin
            case (mtw_pkg::t_cfg_idx'(i_cfg_index))
                mtw_pkg::CFG_START_X:  r_start[0] <= i_cfg_data[COORD_BITS-1:0];
                mtw_pkg::CFG_START_Y:  r_start[1] <= i_cfg_data[COORD_BITS-1:0];
                mtw_pkg::CFG_START_Z:  r_start[2] <= i_cfg_data[COORD_BITS-1:0];
                mtw_pkg::CFG_DEST_X:   r_dest[0]  <= i_cfg_data[COORD_BITS-1:0];
                mtw_pkg::CFG_DEST_Y:   r_dest[1]  <= i_cfg_data[COORD_BITS-1:0];
                mtw_pkg::CFG_DEST_Z:   r_dest[2]  <= i_cfg_data[COORD_BITS-1:0];
                mtw_pkg::CFG_FIX_TIME: r_fix_time <= i_cfg_data[mtw_pkg::TIME_W-1:0];
                mtw_pkg::CFG_SPEED:    r_speed    <= i_cfg_data[mtw_pkg::SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // leg vector, sign-extended by one bit so the difference never wraps
    always_ff @(posedge i_clk) begin
        logic [COORD_BITS:0] diff;
        logic [COORD_BITS:0] mag;
        for (int a = 0; a < mtw_pkg::AXES; a++) begin
            diff = {r_dest[a][COORD_BITS-1], r_dest[a]}
                 - {r_start[a][COORD_BITS-1], r_start[a]};
            mag  = diff[COORD_BITS] ? -diff : diff;
            r_neg[a]  <= diff[COORD_BITS];
            r_absd[a] <= mag[COORD_BITS-1:0];
        end
    end

    mtw_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cfg_we),
        .i_absd  (r_absd),
        .o_ready (dist_ready),
        .o_dist  (leg_len)
    );

    // whole pipeline moves unless a finished estimate is held
    assign en         = ~r_out_valid | i_out_ready;
    assign o_in_ready = en & dist_ready;

    // stage A: elapsed time, clamped at zero before the fix
    // stage B: elapsed * speed
    // stage C: early reached check, operand for the divide by 1000
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_in_valid & dist_ready;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= div1_v;
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_elapsed <= (i_query_time >= r_fix_time) ? i_query_time - r_fix_time : '0;
            r_b_prod    <= mtw_pkg::PROD_W'(r_a_elapsed) * mtw_pkg::PROD_W'(r_speed);
            r_c_x       <= r_b_prod[X_W-1:0];
            r_c_reached <= (r_speed == '0) | (leg_len == '0) | (r_b_prod >= SAT_LIM);
        end
    end

    // travel = floor(elapsed * speed / 1000)
    mtw_div #(
        .LANES (1),
        .QW    (DIST_W),
        .DW    (mtw_pkg::MS_PER_S_W),
        .SW    (1)
    ) u_div_ms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_v),
        .i_num   (r_c_x),
        .i_den   (mtw_pkg::MS_PER_S_W'(mtw_pkg::MS_PER_S)),
        .i_side  (r_c_reached),
        .o_valid (div1_v),
        .o_quo   (div1_quo),
        .o_side  (div1_side)
    );

    // stage D: final reached decision; stage E: |diff| * travel per axis
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_travel  <= div1_quo;
            r_d_reached <= div1_side | (div1_quo >= leg_len);
            r_e_reached <= r_d_reached;
            for (int a = 0; a < mtw_pkg::AXES; a++) begin
                r_e_prod[a] <= NUM_W'(r_absd[a]) * NUM_W'(r_d_travel);
            end
        end
    end

    // offset magnitude = |diff| * travel / dist, truncated
    mtw_div #(
        .LANES (mtw_pkg::AXES),
        .QW    (COORD_BITS),
        .DW    (DIST_W),
        .SW    (1)
    ) u_div_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_e_v),
        .i_num   (r_e_prod),
        .i_den   (leg_len),
        .i_side  (r_e_reached),
        .o_valid (div2_v),
        .o_quo   (div2_quo),
        .o_side  (div2_side)
    );

    // output register: waypoint when reached, else start stepped toward it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_reached <= div2_side;
            for (int a = 0; a < mtw_pkg::AXES; a++) begin
                if (div2_side) begin
                    r_est[a] <= r_dest[a];
                end else if (r_neg[a]) begin
                    r_est[a] <= r_start[a] - div2_quo[a];
                end else begin
                    r_est[a] <= r_start[a] + div2_quo[a];
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_est_x     = r_est[0];
    assign o_est_y     = r_est[1];
    assign o_est_z     = r_est[2];
    assign o_reached   = r_reached;

    // a register write must hold off queries until the distance is redone
    a_cfg_blocks_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we |=> !o_in_ready)
        else $error("query accepted right after a register write");

    // a non-reached estimate needs a moving vehicle
    a_moving_when_not_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reached) |-> (r_speed != '0))
        else $error("estimate not reached with zero speed");

    // a held estimate freezes the pipeline
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_b_prod) && $stable(r_e_prod)))
        else $error("pipeline moved while estimate held");

endmodule

// ===== dv/mtw_checker.sv =====
`timescale 1ns / 1ps

module mtw_checker #(
    parameter int COORD_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [mtw_pkg::TIME_W-1:0]     i_query_time,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic signed [COORD_BITS-1:0]   i_est_x,
    input  logic signed [COORD_BITS-1:0]   i_est_y,
    input  logic signed [COORD_BITS-1:0]   i_est_z,
    input  logic                           i_reached,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [mtw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic                  reached;
    } t_estimate;

    longint          pos_start [mtw_pkg::AXES];
    longint          pos_dest  [mtw_pkg::AXES];
    logic [31:0]     fix_ms;
    logic [15:0]     speed_mm_s;
    t_estimate       estimate_q [$];

    assign o_pending = estimate_q.size();

    function automatic longint sext_coord(logic [31:0] v);
        logic [COORD_BITS-1:0] m;
        m = v[COORD_BITS-1:0];
        return longint'(signed'(m));
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic t_estimate predict_position(logic [31:0] q);
        t_estimate       e;
        longint unsigned elapsed, sq, leg_len, travel, mag, quo;
        longint          diff, res [mtw_pkg::AXES];
        elapsed = (q >= fix_ms) ? longint'(q - fix_ms) : 0;
        sq = 0;
        for (int a = 0; a < mtw_pkg::AXES; a++) begin
            diff = pos_dest[a] - pos_start[a];
            mag  = diff < 0 ? -diff : diff;
            sq  += mag * mag;
        end
        leg_len = floor_sqrt(sq);
        travel  = (elapsed * speed_mm_s) / mtw_pkg::MS_PER_S;
        if (speed_mm_s == 0 || travel >= leg_len) begin
            for (int a = 0; a < mtw_pkg::AXES; a++) res[a] = pos_dest[a];
            e.reached = 1'b1;
        end else begin
            for (int a = 0; a < mtw_pkg::AXES; a++) begin
                diff = pos_dest[a] - pos_start[a];
                mag  = diff < 0 ? -diff : diff;
                quo  = (mag * travel) / leg_len;
                res[a] = diff < 0 ? pos_start[a] - longint'(quo)
                                  : pos_start[a] + longint'(quo);
            end
            e.reached = 1'b0;
        end
        e.x = res[0][COORD_BITS-1:0];
        e.y = res[1][COORD_BITS-1:0];
        e.z = res[2][COORD_BITS-1:0];
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_estimate exp_e;
        if (!i_rst_n) begin
            for (int a = 0; a < mtw_pkg::AXES; a++) begin
                pos_start[a] = 0;
                pos_dest[a]  = 0;
            end
            fix_ms       = 0;
            speed_mm_s   = 1;
            o_fail_count = 0;
            estimate_q.delete();
        end else begin
            // outputs are compared first: a config request only ever comes while idle
            if (i_out_valid && i_out_ready) begin
                if (estimate_q.size() == 0) begin
                    $display("%0t: unexpected estimate x=%0d y=%0d z=%0d r=%0b", $time,
                             i_est_x, i_est_y, i_est_z, i_reached);
                    o_fail_count++;
                end else begin
                    exp_e = estimate_q.pop_front();
                    if (exp_e.x !== i_est_x || exp_e.y !== i_est_y ||
                        exp_e.z !== i_est_z || exp_e.reached !== i_reached) begin
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d r=%0b",
                                 $time, signed'(exp_e.x), signed'(exp_e.y),
                                 signed'(exp_e.z), exp_e.reached);
                        $display("%0t:          actual   x=%0d y=%0d z=%0d r=%0b",
                                 $time, i_est_x, i_est_y, i_est_z, i_reached);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                estimate_q.push_back(predict_position(i_query_time));
            if (i_cfg_valid && i_cfg_ready) begin
                case (mtw_pkg::t_cfg_idx'(i_cfg_index))
                    mtw_pkg::CFG_START_X:  pos_start[0] = sext_coord(i_cfg_data);
                    mtw_pkg::CFG_START_Y:  pos_start[1] = sext_coord(i_cfg_data);
                    mtw_pkg::CFG_START_Z:  pos_start[2] = sext_coord(i_cfg_data);
                    mtw_pkg::CFG_DEST_X:   pos_dest[0]  = sext_coord(i_cfg_data);
                    mtw_pkg::CFG_DEST_Y:   pos_dest[1]  = sext_coord(i_cfg_data);
                    mtw_pkg::CFG_DEST_Z:   pos_dest[2]  = sext_coord(i_cfg_data);
                    mtw_pkg::CFG_FIX_TIME: fix_ms       = i_cfg_data;
                    mtw_pkg::CFG_SPEED:    speed_mm_s   = i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== dv/move_toward_waypoint_estimator_tb.sv =====
`timescale 1ns / 1ps

module move_toward_waypoint_estimator_tb;

    localparam int COORD_BITS = 24;
    localparam int LATENCY    = 2 * COORD_BITS + 8;
    localparam int CYCLE_CAP  = 400000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [mtw_pkg::TIME_W-1:0]     i_query_time;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [COORD_BITS-1:0] o_est_x, o_est_y, o_est_z;
    logic                    o_reached;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [mtw_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mtw_pkg::CFG_DATA_W-1:0] i_cfg_data;

    int  fail_count;
    int  pending;
    int  cycle_cnt;
    bit  quiet_tail;     // no idling on either side in the last stretch
    bit  hold_sink;      // long receiver hold-off requested
    logic [31:0] cur_fix;

    move_toward_waypoint_estimator #(.COORD_BITS(COORD_BITS)) u_top (.*);

    mtw_checker #(.COORD_BITS(COORD_BITS)) u_chk (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready), .i_query_time,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_est_x(o_est_x), .i_est_y(o_est_y), .i_est_z(o_est_z),
        .i_reached(o_reached),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("move_toward_waypoint_estimator_tb: FAIL");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_sink && !held) begin
                i_out_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                held = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 4);
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // valid stays up after the write; the caller drops it after the last one
    task automatic write_reg(mtw_pkg::t_cfg_idx idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (idx == mtw_pkg::CFG_FIX_TIME) cur_fix = data;
    endtask

    // valid stays up so the next request can follow at once
    task automatic send_query(logic [31:0] t);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_query_time <= t;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drain outstanding estimates, then let the pipe settle before a register write
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // random coordinate: mostly small, sometimes near full scale, raw upper bits noisy
    function automatic logic [31:0] rand_coord(bit wide);
        logic [31:0] v;
        v = $urandom();
        if (!wide) v = 32'(int'($urandom_range(0, 4000)) - 2000) ^ (v & 32'hFF00_0000);
        return v;
    endfunction

    task automatic program_path(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                logic [31:0] fix, logic [31:0] spd);
        drain_pipe();
        write_reg(mtw_pkg::CFG_START_X, sx);
        write_reg(mtw_pkg::CFG_START_Y, sy);
        write_reg(mtw_pkg::CFG_START_Z, sz);
        write_reg(mtw_pkg::CFG_DEST_X, dx);
        write_reg(mtw_pkg::CFG_DEST_Y, dy);
        write_reg(mtw_pkg::CFG_DEST_Z, dz);
        write_reg(mtw_pkg::CFG_FIX_TIME, fix);
        write_reg(mtw_pkg::CFG_SPEED, spd);
        i_cfg_valid <= 1'b0;
    endtask

    // query time around the interesting span of the current path
    function automatic logic [31:0] rand_query();
        logic [31:0] t;
        case ($urandom_range(0, 5))
            0:       t = $urandom();
            1:       t = cur_fix - $urandom_range(0, 50);
            default: t = cur_fix + $urandom_range(0, 3000000);
        endcase
        return t;
    endfunction

    initial begin
        bit wide;
        quiet_tail  = 1'b0;
        hold_sink   = 1'b0;
        cur_fix     = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_query_time = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset state: start equals waypoint, always reached
        send_query(32'd0);
        send_query(32'hFFFF_FFFF);

        // extremes: opposite corners, max speed, fix at zero
        program_path(32'h0080_0000, 32'h0080_0000, 32'h0080_0000,
                     32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF, 32'd0, 32'h0000_FFFF);
        send_query(32'd0);
        send_query(32'd1);
        send_query(32'd100000);
        send_query(32'd253000);
        send_query(32'hFFFF_FFFF);
        // early query, zero speed, garbage upper bits, unknown-style wide data
        program_path(32'hFF00_0010, 32'h00FF_FFF0, 32'd5, 32'hABFF_FF00, 32'd300,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0000);
        send_query(32'd0);
        send_query(32'hFFFF_FFFE);
        send_query(32'hFFFF_FFFF);
        program_path(32'd10, 32'd20, 32'd30, 32'd1010, 32'd20, 32'd30,
                     32'd5000, 32'd1000);
        send_query(32'd4999);
        send_query(32'd5000);
        send_query(32'd5500);
        send_query(32'd5999);
        send_query(32'd6000);
        send_query(32'd1000000);
        program_path(32'd7, 32'd7, 32'd7, 32'd7, 32'd7, 32'd7, 32'd100, 32'd0);
        send_query(32'd50);
        send_query(32'd200);

        // random paths with bursts of queries
        for (int ph = 0; ph < 40; ph++) begin
            wide = ($urandom_range(0, 3) == 0);
            program_path(rand_coord(wide), rand_coord(wide), rand_coord(wide),
                         rand_coord(wide), rand_coord(wide), rand_coord(wide),
                         $urandom(), ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
                                                                   : $urandom());
            if (ph == 10) hold_sink = 1'b1;
            if (ph == 34) quiet_tail = 1'b1;
            for (int k = 0; k < 43; k++) send_query(rand_query());
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0)
            $display("move_toward_waypoint_estimator_tb: PASS");
        else
            $display("move_toward_waypoint_estimator_tb: FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/mtw_pkg.sv
rtl/core/mtw_div.sv
rtl/core/mtw_dist.sv
rtl/core/move_toward_waypoint_estimator.sv
dv/mtw_checker.sv
dv/move_toward_waypoint_estimator_tb.sv
